// ===== sv/tat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tat_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int CRED_SLOTS    = 64;
    localparam int ENT_IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int CUR_W   = 7;
    localparam int CNT_W   = 5;
    localparam logic [CUR_W-1:0] SLOTS_END = CUR_W'(CRED_SLOTS);

    typedef enum logic [FUNC_W-1:0] {
        F_ADD    = 3'd0,
        F_REMOVE = 3'd1,
        F_PRUNE  = 3'd2,
        F_NOTE   = 3'd3,
        F_NEXT   = 3'd4,
        F_FORGET = 3'd5
    } func_t;

    typedef struct packed {
        logic claim;
        logic refresh;
        logic free;
    } ent_ctl_t;

    typedef struct packed {
        logic used;
        logic match;
        logic expired;
    } ent_stat_t;

    typedef struct packed {
        logic              clr_en;
        logic [ADDR_W-1:0] addr;
    } slot_bus_t;

    typedef struct packed {
        logic tok;
        logic hit;
    } slot_stat_t;
endpackage
`default_nettype wire

// ===== sv/tat_entry_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tat_entry_cell import tat_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ent_ctl_t          ctl,
    input  wire logic [ADDR_W-1:0] cmp_addr,
    input  wire logic [31:0]       expiry,
    input  wire logic [31:0]       now,
    output ent_stat_t              stat,
    output logic [ADDR_W-1:0]      address_out
);
    logic              used_reg, used_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [31:0]       exp_reg, exp_next;
    logic [31:0]       diff;

    assign diff         = now - exp_reg;
    assign stat.used    = used_reg;
    assign stat.match   = used_reg && (addr_reg == cmp_addr);
    assign stat.expired = used_reg && !diff[31];
    assign address_out  = addr_reg;

    always_comb
    begin
        used_next = used_reg;
        addr_next = addr_reg;
        exp_next  = exp_reg;
        if (ctl.claim)
        begin
            used_next = 1'b1;
            addr_next = cmp_addr;
            exp_next  = expiry;
        end
        else if (ctl.refresh)
        begin
            exp_next = expiry;
        end
        else if (ctl.free)
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            addr_reg <= '0;
            exp_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            addr_reg <= addr_next;
            exp_reg  <= exp_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/tat_slot_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tat_slot_cell import tat_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slot_bus_t         bus,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_data,
    input  wire logic              inject,
    input  wire logic              tok_in,
    output logic                   tok_out,
    output slot_stat_t             stat
);
    logic [ADDR_W-1:0] row_reg, row_next;
    logic              tok_reg, tok_next;
    logic              hit;

    // stop the search token here on a match, otherwise hand it on
    assign hit      = tok_reg && (row_reg == bus.addr);
    assign tok_out  = tok_reg && !hit;
    assign stat.tok = tok_reg;
    assign stat.hit = hit;
    assign tok_next = inject || tok_in;

    always_comb
    begin
        row_next = row_reg;
        if (wr_en)
            row_next = wr_data;
        else if (bus.clr_en && (row_reg == bus.addr))
            row_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            tok_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            tok_reg <= tok_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/timed_address_allow_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake               Payload
// in       in_valid / in_ready     func, address, ttl_ms, now_ms, cred_slot, cursor
// out      out_valid / out_ready   ok, removed_count, found_slot, next_cursor
//
// Add, remove, note, forget and unused codes go from the execute step to the done step.
// Prune adds a sweep over every entry, clearing the slot rows of the expired ones.
// Next may walk the slot cells, the search token moving one slot cell per cycle.
// Reset clears every entry and every slot row at once.
// A result waiting on out_ready holds the next item in its final step; in_ready
// returns as soon as the current item leaves the engine.
module timed_address_allow_table import tat_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [31:0]       ttl_ms,
    input  wire logic [31:0]       now_ms,
    input  wire logic [SLOT_W-1:0] cred_slot,
    input  wire logic [CUR_W-1:0]  cursor,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   ok,
    output logic [CNT_W-1:0]       removed_count,
    output logic [SLOT_W-1:0]      found_slot,
    output logic [CUR_W-1:0]       next_cursor
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0] func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       ttl_reg, now_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CUR_W-1:0]  cur_reg;

    logic              r_ok_reg, r_ok_next;
    logic [CNT_W-1:0]  r_cnt_reg, r_cnt_next;
    logic [SLOT_W-1:0] r_found_reg, r_found_next;
    logic [CUR_W-1:0]  r_cur_reg, r_cur_next;

    logic [TABLE_ENTRIES-1:0] exp_mask_reg, exp_mask_next;
    logic [ENT_IW-1:0]        sweep_reg, sweep_next;

    logic              out_valid_reg;
    logic              ok_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] found_reg;
    logic [CUR_W-1:0]  ncur_reg;

    ent_ctl_t          ent_ctl  [TABLE_ENTRIES];
    ent_stat_t         ent_stat [TABLE_ENTRIES];
    logic [ADDR_W-1:0] ent_addr [TABLE_ENTRIES];

    slot_bus_t         sbus;
    logic [CRED_SLOTS-1:0] s_wr, s_inject, s_tok, s_hit;
    logic [CRED_SLOTS:0]   chain;
    logic [ADDR_W-1:0]     s_wr_data;

    logic                  match_any, free_any, in_fire, load_out;
    logic [ENT_IW-1:0]     match_idx, free_idx;
    logic [TABLE_ENTRIES-1:0] expired_vec;
    logic [CNT_W-1:0]      exp_count;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  slot_in_range, cur_in_range;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_ent
            tat_entry_cell u_ent (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ent_ctl[g]),
                .cmp_addr    (addr_reg),
                .expiry      (now_reg + ttl_reg),
                .now         (now_reg),
                .stat        (ent_stat[g]),
                .address_out (ent_addr[g])
            );
            assign expired_vec[g] = ent_stat[g].expired;
        end
        for (g = 0; g < CRED_SLOTS; g++)
        begin : g_slot
            slot_stat_t st;
            tat_slot_cell u_slot (
                .clk     (clk),
                .rst_n   (rst_n),
                .bus     (sbus),
                .wr_en   (s_wr[g]),
                .wr_data (s_wr_data),
                .inject  (s_inject[g]),
                .tok_in  (chain[g]),
                .tok_out (chain[g+1]),
                .stat    (st)
            );
            assign s_tok[g] = st.tok;
            assign s_hit[g] = st.hit;
        end
    endgenerate
    assign chain[0] = 1'b0;

    // first match, first free, expiry count
    always_comb
    begin
        match_any = 1'b0;
        free_any  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        exp_count = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (ent_stat[i].match)
            begin
                match_any = 1'b1;
                match_idx = ENT_IW'(i);
            end
            if (!ent_stat[i].used)
            begin
                free_any = 1'b1;
                free_idx = ENT_IW'(i);
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
            exp_count = exp_count + CNT_W'(expired_vec[i]);
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < CRED_SLOTS; i++)
            if (s_hit[i])
                hit_idx = hit_idx | SLOT_W'(i);
    end

    assign slot_in_range = ({1'b0, slot_reg} < SLOTS_END);
    assign cur_in_range  = (cur_reg < SLOTS_END);

    always_comb
    begin
        state_next    = state_reg;
        r_ok_next     = r_ok_reg;
        r_cnt_next    = r_cnt_reg;
        r_found_next  = r_found_reg;
        r_cur_next    = r_cur_reg;
        exp_mask_next = exp_mask_reg;
        sweep_next    = sweep_reg;
        sbus.clr_en   = 1'b0;
        sbus.addr     = addr_reg;
        s_wr          = '0;
        s_wr_data     = addr_reg;
        s_inject      = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            ent_ctl[i] = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                r_ok_next    = 1'b0;
                r_cnt_next   = '0;
                r_found_next = '0;
                r_cur_next   = '0;
                state_next   = S_DONE;
                case (func_reg)
                    F_ADD:
                    begin
                        if (match_any)
                            ent_ctl[match_idx].refresh = 1'b1;
                        else if (free_any)
                            ent_ctl[free_idx].claim = 1'b1;
                        r_ok_next = match_any || free_any;
                    end
                    F_REMOVE:
                    begin
                        if (match_any)
                        begin
                            ent_ctl[match_idx].free = 1'b1;
                            sbus.clr_en = 1'b1;
                        end
                        r_ok_next = match_any;
                    end
                    F_PRUNE:
                    begin
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                            ent_ctl[i].free = expired_vec[i];
                        exp_mask_next = expired_vec;
                        r_cnt_next    = exp_count;
                        sweep_next    = '0;
                        state_next    = S_SWEEP;
                    end
                    F_NOTE:
                    begin
                        if ((addr_reg != '0) && slot_in_range && match_any)
                        begin
                            s_wr[slot_reg] = 1'b1;
                            r_ok_next = 1'b1;
                        end
                    end
                    F_NEXT:
                    begin
                        if (addr_reg == '0)
                            r_cur_next = cur_reg;
                        else if (!cur_in_range)
                            r_cur_next = SLOTS_END;
                        else
                        begin
                            s_inject[cur_reg[SLOT_W-1:0]] = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    F_FORGET:
                    begin
                        if (slot_in_range)
                        begin
                            s_wr[slot_reg] = 1'b1;
                            s_wr_data = '0;
                        end
                    end
                    default: ;
                endcase
            end
            S_SWEEP:
            begin
                // visit one entry per cycle, clearing the rows of an expired one
                sbus.clr_en = exp_mask_reg[sweep_reg];
                sbus.addr   = ent_addr[sweep_reg];
                sweep_next  = sweep_reg + 1'b1;
                if (sweep_reg == ENT_IW'(TABLE_ENTRIES - 1))
                    state_next = S_DONE;
            end
            S_WALK:
            begin
                if (s_hit != '0)
                begin
                    r_ok_next    = 1'b1;
                    r_found_next = hit_idx;
                    r_cur_next   = CUR_W'(hit_idx) + 1'b1;
                    state_next   = S_DONE;
                end
                else if (chain[CRED_SLOTS])
                begin
                    r_cur_next = SLOTS_END;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func;
            addr_reg <= address;
            ttl_reg  <= ttl_ms;
            now_reg  <= now_ms;
            slot_reg <= cred_slot;
            cur_reg  <= cursor;
        end
        r_ok_reg     <= r_ok_next;
        r_cnt_reg    <= r_cnt_next;
        r_found_reg  <= r_found_next;
        r_cur_reg    <= r_cur_next;
        exp_mask_reg <= exp_mask_next;
        sweep_reg    <= sweep_next;
        if (load_out)
        begin
            ok_reg    <= r_ok_reg;
            cnt_reg   <= r_cnt_reg;
            found_reg <= r_found_reg;
            ncur_reg  <= r_cur_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign removed_count = cnt_reg;
    assign found_slot    = found_reg;
    assign next_cursor   = ncur_reg;

    a_tok_single: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(s_tok))
        else $error("more than one search token in the slot chain");
    a_tok_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tok != '0) |-> (state_reg == S_WALK))
        else $error("search token outside a walk");
    a_state_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_walk_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (func_reg == F_NEXT))
        else $error("walk entered for an operation other than next");
endmodule
`default_nettype wire
